@@ rtl/ppp_pkg.sv @@
// Shared constants and control types for the pinhole point projector.
`timescale 1ns / 1ps
package ppp_pkg;

   localparam int POINT_WIDTH_DEF  = 32;
   localparam int RESULT_WIDTH_DEF = 48;
   localparam int FIELD_W          = 32;
   localparam int COEF_W           = 32;
   localparam int CSR_W            = 64;
   localparam int CSR_IDX_W        = 3;
   localparam int MIN_W            = 47;
   localparam int NUM_COEF_REGS    = 6;

   localparam logic [FIELD_W-1:0] ONE_Q16      = 32'h0001_0000;
   localparam logic [MIN_W-1:0]   MIN_ALL_ONES = {MIN_W{1'b1}};

   // register indexes on the csr port
   localparam logic [CSR_IDX_W-1:0] CSR_U_XY  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_U_ZW  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_V_XY  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_V_ZW  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_S_XY  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_S_ZW  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_HOMOG = 3'd6;

   typedef struct packed {
      logic       load;
      logic       mul_en;
      logic [1:0] mul_row;
      logic [1:0] mul_col;
      logic       div_load;
      logic       div_step;
      logic       finish;
   } ppp_cmd_type;

   typedef struct packed {
      logic mul_busy;
   } ppp_status_type;

endpackage

@@ rtl/ppp_if.sv @@
// Valid/ready channel interfaces for point requests and projection responses.
`timescale 1ns / 1ps
interface ppp_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] point_x;
   logic [31:0] point_y;
   logic [31:0] point_z;
   logic [31:0] point_w;
   logic        last_point;

   modport source (output valid, point_x, point_y, point_z, point_w, last_point,
                   input ready);
   modport sink   (input valid, point_x, point_y, point_z, point_w, last_point,
                   output ready);
endinterface

interface ppp_rsp_if #(parameter int RESULT_WIDTH = 48);
   logic                    valid;
   logic                    ready;
   logic [RESULT_WIDTH-1:0] coord_u;
   logic [RESULT_WIDTH-1:0] coord_v;
   logic [RESULT_WIDTH-1:0] coord_depth;
   logic [46:0]             min_abs_depth;
   logic                    zero_depth;
   logic                    batch_end;

   modport source (output valid, coord_u, coord_v, coord_depth, min_abs_depth,
                   zero_depth, batch_end, input ready);
   modport sink   (input valid, coord_u, coord_v, coord_depth, min_abs_depth,
                   zero_depth, batch_end, output ready);
endinterface

@@ rtl/ppp_datapath.sv @@
// Projector datapath: coefficient registers, shared multiplier, row sums, divider.
`timescale 1ns / 1ps
module ppp_datapath import ppp_pkg::*; #(
   parameter int POINT_WIDTH  = POINT_WIDTH_DEF,
   parameter int RESULT_WIDTH = RESULT_WIDTH_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_we,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [CSR_W-1:0]        csr_wdata,
   input  logic [FIELD_W-1:0]      in_x,
   input  logic [FIELD_W-1:0]      in_y,
   input  logic [FIELD_W-1:0]      in_z,
   input  logic [FIELD_W-1:0]      in_w,
   input  logic                    in_last,
   input  ppp_cmd_type             cmd,
   output ppp_status_type          status,
   output logic [RESULT_WIDTH-1:0] u_out,
   output logic [RESULT_WIDTH-1:0] v_out,
   output logic [RESULT_WIDTH-1:0] d_out,
   output logic [MIN_W-1:0]        min_out,
   output logic                    zero_out,
   output logic                    last_out
);

   localparam int AW = 2 * COEF_W + 2;
   localparam int MW = RESULT_WIDTH;
   localparam int DW = RESULT_WIDTH + 16;
   localparam int SH = FIELD_W - POINT_WIDTH;
   localparam logic signed [AW-1:0] RMAX =
      signed'((AW'(1) << (RESULT_WIDTH - 1)) - AW'(1));
   localparam logic signed [AW-1:0] RMIN = ~RMAX;
   localparam logic [DW-1:0] LIM_POS = DW'(RMAX[RESULT_WIDTH-1:0]);
   localparam logic [DW-1:0] LIM_NEG = LIM_POS + DW'(1);
   localparam logic [RESULT_WIDTH-1:0] OUT_MAX = RMAX[RESULT_WIDTH-1:0];
   localparam logic [RESULT_WIDTH-1:0] OUT_MIN = RMIN[RESULT_WIDTH-1:0];

   logic [CSR_W-1:0] coef_ff [NUM_COEF_REGS];
   logic             homog_ff;

   logic signed [FIELD_W-1:0] pt_ff [4];
   logic                      last_ff;

   logic signed [2*COEF_W-1:0] prod_ff;
   logic                       pv_ff;
   logic [1:0]                 prow_ff, pcol_ff;
   logic signed [AW-1:0]       acc_ff;
   logic                       av_ff;
   logic [1:0]                 arow_ff;
   logic [RESULT_WIDTH-1:0]    su_ff, sv_ff, sd_ff;

   logic [DW-1:0] nu_ff, nv_ff, qu_ff, qv_ff;
   logic [MW-1:0] ru_ff, rv_ff, dm_ff;
   logic          negu_ff, negv_ff;

   logic [MIN_W-1:0] min_ff;

   logic [CSR_W-1:0]           coef_word;
   logic signed [COEF_W-1:0]   coef_op;
   logic signed [AW-1:0]       acc_in, floor_sum, sat_sum;
   logic [MW:0]                remu_in, remv_in;
   logic                       geu, gev;
   logic [DW-1:0]              qcu, qcv;
   logic [RESULT_WIDTH-1:0]    divu, divv;
   logic                       depth_zero;
   logic [63:0]                dmag64;
   logic [MIN_W-1:0]           dcap, min_new;

   function automatic logic signed [FIELD_W-1:0] sext_pt(input logic [FIELD_W-1:0] v);
      logic [FIELD_W-1:0] t;
      t = v << SH;
      return signed'(t) >>> SH;
   endfunction

   function automatic logic [MW-1:0] mag(input logic [RESULT_WIDTH-1:0] v);
      return v[RESULT_WIDTH-1] ? MW'(-v) : MW'(v);
   endfunction

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff[CSR_U_XY] <= CSR_W'(64'h0000_0000_0001_0000);
         coef_ff[CSR_U_ZW] <= '0;
         coef_ff[CSR_V_XY] <= CSR_W'(64'h0001_0000_0000_0000);
         coef_ff[CSR_V_ZW] <= '0;
         coef_ff[CSR_S_XY] <= '0;
         coef_ff[CSR_S_ZW] <= CSR_W'(64'h0000_0000_0001_0000);
         homog_ff          <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_U_XY, CSR_U_ZW, CSR_V_XY, CSR_V_ZW, CSR_S_XY, CSR_S_ZW:
               coef_ff[csr_index] <= csr_wdata;
            CSR_HOMOG: homog_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // multiplier operand selection, accumulator input and row-sum saturation
   always_comb begin
      coef_word = coef_ff[{cmd.mul_row, cmd.mul_col[1]}];
      coef_op   = signed'(cmd.mul_col[0] ? coef_word[CSR_W-1:COEF_W]
                                         : coef_word[COEF_W-1:0]);
      acc_in    = ((pcol_ff == 2'd0) ? '0 : acc_ff) + AW'(prod_ff);
      floor_sum = acc_ff >>> 16;
      if (floor_sum > RMAX)      sat_sum = RMAX;
      else if (floor_sum < RMIN) sat_sum = RMIN;
      else                       sat_sum = floor_sum;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pv_ff <= 1'b0;
         av_ff <= 1'b0;
      end else begin
         pv_ff <= cmd.mul_en;
         av_ff <= pv_ff && (pcol_ff == 2'd3);
      end
      if (cmd.load) begin
         pt_ff[0] <= sext_pt(in_x);
         pt_ff[1] <= sext_pt(in_y);
         pt_ff[2] <= sext_pt(in_z);
         pt_ff[3] <= homog_ff ? sext_pt(in_w) : signed'(ONE_Q16);
         last_ff  <= in_last;
      end
      prod_ff <= coef_op * pt_ff[cmd.mul_col];
      prow_ff <= cmd.mul_row;
      pcol_ff <= cmd.mul_col;
      if (pv_ff) acc_ff <= acc_in;
      arow_ff <= prow_ff;
      if (av_ff) begin
         case (arow_ff)
            2'd0:    su_ff <= sat_sum[RESULT_WIDTH-1:0];
            2'd1:    sv_ff <= sat_sum[RESULT_WIDTH-1:0];
            default: sd_ff <= sat_sum[RESULT_WIDTH-1:0];
         endcase
      end
   end

   assign status.mul_busy = pv_ff | av_ff;

   // two restoring division lanes, one quotient bit per cycle
   always_comb begin
      remu_in = {ru_ff, nu_ff[DW-1]};
      remv_in = {rv_ff, nv_ff[DW-1]};
      geu     = remu_in >= {1'b0, dm_ff};
      gev     = remv_in >= {1'b0, dm_ff};
   end

   always_ff @(posedge clock) begin
      if (cmd.div_load) begin
         nu_ff   <= {mag(su_ff), 16'b0};
         nv_ff   <= {mag(sv_ff), 16'b0};
         dm_ff   <= mag(sd_ff);
         ru_ff   <= '0;
         rv_ff   <= '0;
         qu_ff   <= '0;
         qv_ff   <= '0;
         negu_ff <= su_ff[RESULT_WIDTH-1] ^ sd_ff[RESULT_WIDTH-1];
         negv_ff <= sv_ff[RESULT_WIDTH-1] ^ sd_ff[RESULT_WIDTH-1];
      end else if (cmd.div_step) begin
         nu_ff <= nu_ff << 1;
         nv_ff <= nv_ff << 1;
         ru_ff <= geu ? MW'(remu_in - {1'b0, dm_ff}) : MW'(remu_in);
         rv_ff <= gev ? MW'(remv_in - {1'b0, dm_ff}) : MW'(remv_in);
         qu_ff <= {qu_ff[DW-2:0], geu};
         qv_ff <= {qv_ff[DW-2:0], gev};
      end
   end

   // result assembly
   always_comb begin
      qcu = negu_ff ? ((qu_ff > LIM_NEG) ? LIM_NEG : qu_ff)
                    : ((qu_ff > LIM_POS) ? LIM_POS : qu_ff);
      qcv = negv_ff ? ((qv_ff > LIM_NEG) ? LIM_NEG : qv_ff)
                    : ((qv_ff > LIM_POS) ? LIM_POS : qv_ff);
      divu = negu_ff ? RESULT_WIDTH'(-qcu) : RESULT_WIDTH'(qcu);
      divv = negv_ff ? RESULT_WIDTH'(-qcv) : RESULT_WIDTH'(qcv);
      depth_zero = (sd_ff == '0);
      dmag64  = 64'(dm_ff);
      dcap    = (dmag64 > 64'(MIN_ALL_ONES)) ? MIN_ALL_ONES : dmag64[MIN_W-1:0];
      min_new = (!homog_ff && (dcap < min_ff)) ? dcap : min_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff <= MIN_ALL_ONES;
      end else if (cmd.finish) begin
         min_ff <= last_ff ? MIN_ALL_ONES : min_new;
      end
      if (cmd.finish) begin
         if (homog_ff) begin
            u_out    <= su_ff;
            v_out    <= sv_ff;
            zero_out <= 1'b0;
         end else if (depth_zero) begin
            u_out    <= su_ff[RESULT_WIDTH-1] ? OUT_MIN : OUT_MAX;
            v_out    <= sv_ff[RESULT_WIDTH-1] ? OUT_MIN : OUT_MAX;
            zero_out <= 1'b1;
         end else begin
            u_out    <= divu;
            v_out    <= divv;
            zero_out <= 1'b0;
         end
         d_out    <= sd_ff;
         min_out  <= min_new;
         last_out <= last_ff;
      end
   end

endmodule

@@ rtl/ppp_ctrl.sv @@
// Projector sequencer: multiply schedule, division count and output handshake.
`timescale 1ns / 1ps
module ppp_ctrl import ppp_pkg::*; #(
   parameter int RESULT_WIDTH = RESULT_WIDTH_DEF
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   input  ppp_status_type status,
   output ppp_cmd_type    cmd
);

   localparam int DW = RESULT_WIDTH + 16;
   localparam int CW = $clog2(DW);

   typedef enum logic [2:0] {S_IDLE, S_MUL, S_DRAIN, S_DIV, S_DONE} state_type;

   state_type state_ff;
   logic [CW-1:0] cnt_ff;
   logic          rsp_valid_ff;
   logic          out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd          = '0;
      cmd.mul_row  = cnt_ff[3:2];
      cmd.mul_col  = cnt_ff[1:0];
      cmd.load     = (state_ff == S_IDLE) && req_valid;
      cmd.mul_en   = (state_ff == S_MUL);
      cmd.div_load = (state_ff == S_DRAIN) && !status.mul_busy;
      cmd.div_step = (state_ff == S_DIV);
      cmd.finish   = (state_ff == S_DONE) && out_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.finish)     rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               cnt_ff <= '0;
               if (req_valid) state_ff <= S_MUL;
            end
            S_MUL: begin
               cnt_ff <= cnt_ff + CW'(1);
               if (cnt_ff == CW'(11)) state_ff <= S_DRAIN;
            end
            S_DRAIN: begin
               cnt_ff <= '0;
               if (!status.mul_busy) state_ff <= S_DIV;
            end
            S_DIV: begin
               cnt_ff <= cnt_ff + CW'(1);
               if (cnt_ff == CW'(DW - 1)) state_ff <= S_DONE;
            end
            S_DONE: begin
               if (out_free) state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

`ifndef SYNTHESIS
   a_finish_slot: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> (!rsp_valid_ff || rsp_ready))
      else $error("result written over an untaken word");
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && req_valid) |=> (state_ff == S_MUL && cnt_ff == '0))
      else $error("accepted word did not start the multiply schedule");
   a_div_length: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV && cnt_ff == CW'(DW - 1)) |=> (state_ff == S_DONE))
      else $error("division ran past its bit count");
   a_div_after_drain: assert property (@(posedge clock) disable iff (reset)
      cmd.div_load |-> !status.mul_busy)
      else $error("division loaded before row sums settled");
`endif

endmodule

@@ rtl/pinhole_point_projector.sv @@
// Points are processed one at a time: twelve products on one shared 32x32 multiplier
// plus a one-bit-per-cycle divider over RESULT_WIDTH + 16 bits.
// A new point is taken while the previous result waits in the output register.
// Reset is synchronous: coefficients return to identity, mode Euclidean, minimum all ones.
`timescale 1ns / 1ps
module pinhole_point_projector import ppp_pkg::*; #(
   parameter int POINT_WIDTH  = POINT_WIDTH_DEF,
   parameter int RESULT_WIDTH = RESULT_WIDTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   ppp_req_if.sink              req_port,
   ppp_rsp_if.source            rsp_port,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata
);

   ppp_cmd_type    cmd;
   ppp_status_type status;

   ppp_ctrl #(.RESULT_WIDTH(RESULT_WIDTH)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_port.valid),
      .req_ready (req_port.ready),
      .rsp_valid (rsp_port.valid),
      .rsp_ready (rsp_port.ready),
      .status    (status),
      .cmd       (cmd)
   );

   ppp_datapath #(.POINT_WIDTH(POINT_WIDTH), .RESULT_WIDTH(RESULT_WIDTH)) u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .in_x      (req_port.point_x),
      .in_y      (req_port.point_y),
      .in_z      (req_port.point_z),
      .in_w      (req_port.point_w),
      .in_last   (req_port.last_point),
      .cmd       (cmd),
      .status    (status),
      .u_out     (rsp_port.coord_u),
      .v_out     (rsp_port.coord_v),
      .d_out     (rsp_port.coord_depth),
      .min_out   (rsp_port.min_abs_depth),
      .zero_out  (rsp_port.zero_depth),
      .last_out  (rsp_port.batch_end)
   );

endmodule

@@ test/tb_pinhole_point_projector.sv @@
// Self-checking testbench for the pinhole point projector: random and directed points.
`timescale 1ns / 1ps
module tb_pinhole_point_projector import ppp_pkg::*;;

   localparam int RW = 48;
   localparam logic [127:0] RES_MAX = (128'd1 << (RW - 1)) - 1;

   typedef struct packed {
      logic [RW-1:0]    u;
      logic [RW-1:0]    v;
      logic [RW-1:0]    depth;
      logic [MIN_W-1:0] min_depth;
      logic             zero;
      logic             batch_end;
   } projection_type;

   class projection_board_type;
      logic [CSR_W-1:0] coef [NUM_COEF_REGS];
      logic             homog;
      logic [MIN_W-1:0] min_depth;
      projection_type   pending_q [$];
      int               mismatches;

      function void init();
         coef[CSR_U_XY] = 64'd65536;
         coef[CSR_U_ZW] = 64'd0;
         coef[CSR_V_XY] = 64'd65536 << 32;
         coef[CSR_V_ZW] = 64'd0;
         coef[CSR_S_XY] = 64'd0;
         coef[CSR_S_ZW] = 64'd65536;
         homog = 1'b0;
         min_depth = MIN_ALL_ONES;
         mismatches = 0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_W-1:0] val);
         if (idx == CSR_HOMOG) homog = val[0];
         else if (idx < NUM_COEF_REGS) coef[idx] = val;
      endfunction

      function logic signed [127:0] sat(logic signed [127:0] v);
         if (v > $signed(RES_MAX)) return $signed(RES_MAX);
         if (v < -$signed(RES_MAX) - 1) return -$signed(RES_MAX) - 1;
         return v;
      endfunction

      function logic signed [127:0] row_sum(logic [CSR_W-1:0] rxy, logic [CSR_W-1:0] rzw,
                                            logic [31:0] p [4]);
         logic signed [127:0] acc, cw, pw;
         logic [31:0] c [4];
         c[0] = rxy[31:0]; c[1] = rxy[63:32]; c[2] = rzw[31:0]; c[3] = rzw[63:32];
         acc = 0;
         for (int i = 0; i < 4; i++) begin
            cw = $signed(c[i]);
            pw = $signed(p[i]);
            acc = acc + cw * pw;
         end
         return sat(acc >>> 16);
      endfunction

      function logic [127:0] mag(logic signed [127:0] v);
         return v < 0 ? -v : v;
      endfunction

      function logic signed [127:0] q16_div(logic signed [127:0] num,
                                            logic signed [127:0] den);
         logic [127:0] q, lim;
         logic neg;
         neg = (num < 0) != (den < 0);
         lim = neg ? RES_MAX + 1 : RES_MAX;
         q = (mag(num) << 16) / mag(den);
         if (q > lim) q = lim;
         return neg ? -$signed(q) : $signed(q);
      endfunction

      function void note_point(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                               logic [31:0] w, logic last);
         logic [31:0] p [4];
         logic signed [127:0] su, sv, sd, u, v;
         logic [127:0] a;
         projection_type e;
         p[0] = x; p[1] = y; p[2] = z; p[3] = homog ? w : ONE_Q16;
         su = row_sum(coef[CSR_U_XY], coef[CSR_U_ZW], p);
         sv = row_sum(coef[CSR_V_XY], coef[CSR_V_ZW], p);
         sd = row_sum(coef[CSR_S_XY], coef[CSR_S_ZW], p);
         e.zero = 1'b0;
         if (homog) begin
            u = su;
            v = sv;
         end else begin
            a = mag(sd);
            if (a > MIN_ALL_ONES) a = MIN_ALL_ONES;
            if (a < min_depth) min_depth = a[MIN_W-1:0];
            if (sd == 0) begin
               e.zero = 1'b1;
               u = su < 0 ? -$signed(RES_MAX) - 1 : $signed(RES_MAX);
               v = sv < 0 ? -$signed(RES_MAX) - 1 : $signed(RES_MAX);
            end else begin
               u = q16_div(su, sd);
               v = q16_div(sv, sd);
            end
         end
         e.u = u[RW-1:0];
         e.v = v[RW-1:0];
         e.depth = sd[RW-1:0];
         e.min_depth = min_depth;
         e.batch_end = last;
         pending_q.push_back(e);
         if (last) min_depth = MIN_ALL_ONES;
      endfunction

      task report(string what, logic [63:0] got, logic [63:0] want);
         mismatches++;
         $display("MISMATCH %s: got %h want %h", what, got, want);
      endtask

      task check_result(projection_type r);
         projection_type e;
         if (pending_q.size() == 0) begin
            report("unexpected word", 64'(r.u), 64'd0);
            return;
         end
         e = pending_q.pop_front();
         if (r.u !== e.u) report("coord_u", 64'(r.u), 64'(e.u));
         if (r.v !== e.v) report("coord_v", 64'(r.v), 64'(e.v));
         if (r.depth !== e.depth) report("coord_depth", 64'(r.depth), 64'(e.depth));
         if (r.min_depth !== e.min_depth)
            report("min_abs_depth", 64'(r.min_depth), 64'(e.min_depth));
         if (r.zero !== e.zero) report("zero_depth", 64'(r.zero), 64'(e.zero));
         if (r.batch_end !== e.batch_end)
            report("batch_end", 64'(r.batch_end), 64'(e.batch_end));
      endtask
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_W-1:0] csr_wdata = '0;
   logic quiet = 1'b0;
   logic running = 1'b0;

   ppp_req_if req ();
   ppp_rsp_if #(.RESULT_WIDTH(RW)) rsp ();

   pinhole_point_projector dut (
      .clock(clock), .reset(reset), .req_port(req), .rsp_port(rsp),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   projection_board_type board;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   initial begin
      req.valid <= 1'b0;
      req.point_x <= '0;
      req.point_y <= '0;
      req.point_z <= '0;
      req.point_w <= '0;
      req.last_point <= 1'b0;
      rsp.ready <= 1'b0;
   end

   initial begin
      #2000000;
      $display("Mismatches found");
      $finish;
   end

   // response side: random stall bursts, none once quiet
   initial begin
      int stall_left;
      projection_type r;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (running && rsp.valid && rsp.ready) begin
            r.u = rsp.coord_u;
            r.v = rsp.coord_v;
            r.depth = rsp.coord_depth;
            r.min_depth = rsp.min_abs_depth;
            r.zero = rsp.zero_depth;
            r.batch_end = rsp.batch_end;
            board.check_result(r);
         end
         if (!running) rsp.ready <= 1'b0;
         else if (stall_left > 0) begin
            stall_left--;
            rsp.ready <= 1'b0;
         end else if (!quiet && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 6) - 1;
            rsp.ready <= 1'b0;
         end else rsp.ready <= 1'b1;
      end
   end

   function automatic logic [31:0] rand_value();
      case ($urandom_range(0, 5))
         0: return $urandom();
         1: return 32'h7FFF_FFFF;
         2: return 32'h8000_0000;
         3: return $urandom_range(0, 32'h0040_0000) - 32'h0020_0000;
         default: return $urandom_range(0, 32'h0100_0000) - 32'h0080_0000;
      endcase
   endfunction

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_W-1:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      board.write_reg(idx, val);
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic wait_idle();
      while (board.pending_q.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                             logic [31:0] w, logic last);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req.valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req.valid <= 1'b1;
      req.point_x <= x;
      req.point_y <= y;
      req.point_z <= z;
      req.point_w <= w;
      req.last_point <= last;
      do @(posedge clock); while (!req.ready);
      board.note_point(x, y, z, w, last);
   endtask

   task automatic end_burst();
      req.valid <= 1'b0;
   endtask

   task automatic random_points(int n);
      logic [31:0] z;
      for (int i = 0; i < n; i++) begin
         z = ($urandom_range(0, 9) == 0) ? 32'd0 : rand_value();
         send_point(rand_value(), rand_value(), z, rand_value(),
                    $urandom_range(0, 7) == 0);
      end
      end_burst();
   endtask

   function automatic logic [CSR_W-1:0] rand_coefs();
      return {rand_value(), rand_value()};
   endfunction

   initial begin
      board = new();
      board.init();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      running <= 1'b1;

      // identity matrix from reset: extremes, zero depth, negative depth
      send_point(32'h0001_0000, 32'h0002_0000, 32'h0001_0000, 32'd0, 1'b0);
      send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 1'b0);
      send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 1'b0);
      send_point(32'h0003_0000, 32'hFFFD_0000, 32'd0, 32'h8000_0000, 1'b0);
      send_point(32'hFFFF_0000, 32'd0, 32'd0, 32'd0, 1'b1);
      send_point(32'h0005_8000, 32'hFFF0_0000, 32'hFFFE_0000, 32'd0, 1'b0);
      send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1);
      send_point(32'h0000_0001, 32'h0000_0001, 32'h7FFF_FFFF, 32'd0, 1'b0);
      end_burst();
      wait_idle();

      // largest coefficients: row sums saturate, depth magnitude caps
      for (int i = 0; i < NUM_COEF_REGS; i++)
         write_csr(i[CSR_IDX_W-1:0], 64'h7FFF_FFFF_7FFF_FFFF);
      write_csr(CSR_HOMOG, 64'd0);
      send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd0, 1'b0);
      send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'd0, 1'b1);
      send_point(32'd0, 32'd0, 32'd0, 32'd0, 1'b0);
      end_burst();
      wait_idle();

      for (int i = 0; i < NUM_COEF_REGS; i++)
         write_csr(i[CSR_IDX_W-1:0], 64'h8000_0000_8000_0000);
      write_csr(CSR_HOMOG, 64'hFFFF_FFFF_FFFF_FFFF);
      send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
      send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1);
      send_point(32'h0001_0000, 32'd0, 32'd0, 32'h0001_0000, 1'b0);
      end_burst();
      wait_idle();

      // unused index must leave the matrix alone
      write_csr(3'd7, 64'hDEAD_BEEF_0BAD_F00D);
      send_point(32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'h0004_0000, 1'b1);
      end_burst();
      wait_idle();

      for (int phase = 0; phase < 8; phase++) begin
         if (phase == 7) quiet = 1'b1;
         for (int i = 0; i < NUM_COEF_REGS; i++)
            write_csr(i[CSR_IDX_W-1:0], rand_coefs());
         // keep a plain depth row now and then so zero depth turns up
         if (phase % 3 == 0) begin
            write_csr(CSR_S_XY, 64'd0);
            write_csr(CSR_S_ZW, 64'd65536);
         end
         write_csr(CSR_HOMOG, {63'd0, phase[0]});
         random_points(72);
         wait_idle();
      end

      repeat (200) @(posedge clock);
      if (board.mismatches == 0 && board.pending_q.size() == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

@@ files.f @@
rtl/ppp_pkg.sv
rtl/ppp_if.sv
rtl/ppp_datapath.sv
rtl/ppp_ctrl.sv
rtl/pinhole_point_projector.sv
test/tb_pinhole_point_projector.sv
